### rtl/svat_pkg.sv
// Shared types and constants for the SAT variable assignment table.
// Holds table sizing, command codes, request/response payloads and the
// command/status structs between controller and datapath. No dependencies.
package svat_pkg;

    // Table sizing
    localparam int NUM_VARS    = 1024;
    localparam int LEVEL_BITS  = 16;
    localparam int REASON_BITS = 32;
    localparam int ADDR_W      = $clog2(NUM_VARS);

    // Fixed field widths of the request and response
    localparam int CMD_BITS    = 3;
    localparam int VAR_BITS    = 10;
    localparam int OFFSET_BITS = 32;
    localparam int LVL_IN_BITS = 16;
    localparam int TRAIL_BITS  = 16;

    typedef logic [ADDR_W-1:0] addr_t;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_READ        = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ASSIGN      = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_UNASSIGN    = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_BACKTRACK   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_MARK        = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR_MARKS = 3'd5;

    // Read address source
    localparam logic [1:0] RD_SRC_REQ   = 2'd0;
    localparam logic [1:0] RD_SRC_VAR   = 2'd1;
    localparam logic [1:0] RD_SRC_SWEEP = 2'd2;

    // Sweep rewrite modes
    localparam logic [1:0] SWP_ZERO        = 2'd0;
    localparam logic [1:0] SWP_BACKTRACK   = 2'd1;
    localparam logic [1:0] SWP_CLEAR_MARKS = 2'd2;

    typedef struct packed {
        logic [CMD_BITS-1:0]    command;
        logic [VAR_BITS-1:0]    var_id;
        logic                   negated;
        logic                   reason_valid;
        logic [OFFSET_BITS-1:0] reason_offset;
        logic [LVL_IN_BITS-1:0] level_value;
        logic [TRAIL_BITS-1:0]  trail_pos;
    } req_t;

    typedef struct packed {
        logic                   is_assigned;
        logic                   truth_value;
        logic                   reason_present;
        logic [OFFSET_BITS-1:0] reason_ref;
        logic [LVL_IN_BITS-1:0] level_out;
        logic [TRAIL_BITS-1:0]  trail_out;
        logic                   analyzed_out;
    } rsp_t;

    // One stored table entry
    typedef struct packed {
        logic                   assigned;
        logic                   truth;
        logic                   rvalid;
        logic [REASON_BITS-1:0] reason;
        logic [LEVEL_BITS-1:0]  level;
        logic [TRAIL_BITS-1:0]  trail;
        logic                   analyzed;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    // Controller to datapath
    typedef struct packed {
        logic       cap_req;
        logic       rd_en;
        logic [1:0] rd_src;
        logic       sweep_step;
        logic [1:0] sweep_mode;
        logic       exec;
        logic       cap_pend;
        logic       ld_out;
        logic       out_from_pend;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } sts_t;

endpackage

### rtl/sat_variable_assignment_table.sv
// Single-entry commands (read, assign, unassign, mark): the entry is read from the RAM on
// acceptance, updated and written back (not for read), and the response is registered.
// Backtrack and clear-marks sweep every entry through the RAM ports, then read the
// requested entry and respond. req_stall stays high until a request is finished.
// After reset a clearing pass zeroes the table; stall stays high.
// Uses svat_pkg, svat_ctrl, svat_dp and svat_ram.
module sat_variable_assignment_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  svat_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output svat_pkg::rsp_t rsp_data
);

    svat_pkg::ctl_t ctl;
    svat_pkg::sts_t status;

    // Sequence commands
    svat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req_data.command),
        .req_stall (req_stall),
        .status    (status),
        .ctl       (ctl)
    );

    // Store and update entries
    svat_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .ctl       (ctl),
        .status    (status)
    );

endmodule

### rtl/svat_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module svat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/svat_ctrl.sv
// Controller of the SAT variable assignment table: sequences the clearing
// pass, single-entry read-modify-write and full-table sweeps. Uses svat_pkg.
module svat_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic [svat_pkg::CMD_BITS-1:0] req_cmd,
    output logic                         req_stall,
    input  svat_pkg::sts_t               status,
    output svat_pkg::ctl_t               ctl
);

    localparam logic [2:0] S_INIT_SWEEP = 3'd0;
    localparam logic [2:0] S_INIT_DRAIN = 3'd1;
    localparam logic [2:0] S_IDLE       = 3'd2;
    localparam logic [2:0] S_EXEC       = 3'd3;
    localparam logic [2:0] S_HOLD       = 3'd4;
    localparam logic [2:0] S_SWEEP      = 3'd5;
    localparam logic [2:0] S_DRAIN      = 3'd6;
    localparam logic [2:0] S_FINAL_RD   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic       accept;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next        = state_reg;
        mode_next         = mode_reg;
        ctl               = '0;
        ctl.rd_src        = svat_pkg::RD_SRC_REQ;
        ctl.sweep_mode    = mode_reg;
        unique case (state_reg)
            S_INIT_SWEEP:
            begin
                ctl.sweep_step = 1'b1;
                ctl.rd_src     = svat_pkg::RD_SRC_SWEEP;
                ctl.sweep_mode = svat_pkg::SWP_ZERO;
                if (status.sweep_last)
                begin
                    state_next = S_INIT_DRAIN;
                end
            end
            S_INIT_DRAIN:
            begin
                ctl.sweep_mode = svat_pkg::SWP_ZERO;
                state_next     = S_IDLE;
            end
            S_IDLE:
            begin
                ctl.rd_src  = svat_pkg::RD_SRC_REQ;
                ctl.rd_en   = accept;
                ctl.cap_req = accept;
                if (accept)
                begin
                    if (req_cmd == svat_pkg::CMD_BACKTRACK)
                    begin
                        mode_next  = svat_pkg::SWP_BACKTRACK;
                        state_next = S_SWEEP;
                    end
                    else if (req_cmd == svat_pkg::CMD_CLEAR_MARKS)
                    begin
                        mode_next  = svat_pkg::SWP_CLEAR_MARKS;
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_SWEEP:
            begin
                ctl.sweep_step = 1'b1;
                ctl.rd_en      = 1'b1;
                ctl.rd_src     = svat_pkg::RD_SRC_SWEEP;
                if (status.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINAL_RD;
            end
            S_FINAL_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_src = svat_pkg::RD_SRC_VAR;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
                if (status.out_free)
                begin
                    ctl.ld_out = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.cap_pend = 1'b1;
                    state_next   = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (status.out_free)
                begin
                    ctl.ld_out        = 1'b1;
                    ctl.out_from_pend = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and sweep mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_SWEEP;
            mode_reg  <= svat_pkg::SWP_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    // An accepted request goes either to execution or to a sweep
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC || state_reg == S_SWEEP))
        else $error("accepted request took an unexpected path");

    // A sweep ends with a drain state
    a_sweep_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP && status.sweep_last) |=> (state_reg == S_DRAIN))
        else $error("sweep did not drain after last entry");

    // Execution always follows a table read
    a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $past(ctl.rd_en))
        else $error("execute without preceding read");

endmodule

### rtl/svat_dp.sv
// Datapath of the SAT variable assignment table: request register, table
// RAM, sweep counter and pipeline, entry update and response register.
// Uses svat_pkg and svat_ram.
module svat_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  svat_pkg::req_t req_data,
    input  logic           rsp_stall,
    output logic           rsp_valid,
    output svat_pkg::rsp_t rsp_data,
    input  svat_pkg::ctl_t ctl,
    output svat_pkg::sts_t status
);

    svat_pkg::req_t   req_reg;
    svat_pkg::rsp_t   pend_reg;
    svat_pkg::rsp_t   rsp_data_reg;
    logic             rsp_valid_reg, rsp_valid_next;
    svat_pkg::addr_t  cnt_reg, cnt_next;
    svat_pkg::addr_t  s1_addr_reg;
    logic             s1_valid_reg;

    svat_pkg::addr_t  var_addr;
    svat_pkg::addr_t  rd_addr;
    svat_pkg::addr_t  wr_addr;
    svat_pkg::entry_t rd_entry;
    svat_pkg::entry_t wr_entry;
    svat_pkg::entry_t sweep_entry;
    svat_pkg::entry_t exec_entry;
    svat_pkg::rsp_t   exec_rsp;
    logic             wr_en;
    logic             exec_wr;
    logic             in_range;
    logic             sweep_last;

    assign var_addr   = svat_pkg::addr_t'(req_reg.var_id);
    assign in_range   = 32'(req_reg.var_id) < 32'(svat_pkg::NUM_VARS);
    assign sweep_last = (cnt_reg == svat_pkg::addr_t'(svat_pkg::NUM_VARS - 1));

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (ctl.cap_req)
        begin
            req_reg <= req_data;
        end
    end

    // Select the read address
    always_comb
    begin
        unique case (ctl.rd_src)
            svat_pkg::RD_SRC_REQ:   rd_addr = svat_pkg::addr_t'(req_data.var_id);
            svat_pkg::RD_SRC_VAR:   rd_addr = var_addr;
            svat_pkg::RD_SRC_SWEEP: rd_addr = cnt_reg;
            default:                rd_addr = var_addr;
        endcase
    end

    // Advance the sweep counter and the read-to-write stage
    assign cnt_next = sweep_last ? '0 : cnt_reg + svat_pkg::addr_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.sweep_step)
            begin
                cnt_reg <= cnt_next;
            end
            s1_valid_reg <= ctl.sweep_step;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= cnt_reg;
    end

    // Rewrite one swept entry
    always_comb
    begin
        sweep_entry = rd_entry;
        case (ctl.sweep_mode)
            svat_pkg::SWP_BACKTRACK:
            begin
                if (rd_entry.assigned &&
                    (32'(rd_entry.level) > 32'(req_reg.level_value)))
                begin
                    sweep_entry = '0;
                end
            end
            svat_pkg::SWP_CLEAR_MARKS:
            begin
                sweep_entry.analyzed = 1'b0;
            end
            default:
            begin
                sweep_entry = '0;
            end
        endcase
    end

    // Apply a single-entry command
    always_comb
    begin
        exec_entry = rd_entry;
        case (req_reg.command)
            svat_pkg::CMD_ASSIGN:
            begin
                exec_entry.assigned = 1'b1;
                exec_entry.truth    = !req_reg.negated;
                exec_entry.rvalid   = req_reg.reason_valid;
                exec_entry.reason   = req_reg.reason_valid ?
                    svat_pkg::REASON_BITS'(req_reg.reason_offset) : '0;
                exec_entry.level    = svat_pkg::LEVEL_BITS'(req_reg.level_value);
                exec_entry.trail    = req_reg.trail_pos;
                exec_entry.analyzed = 1'b0;
            end
            svat_pkg::CMD_UNASSIGN:
            begin
                exec_entry = '0;
            end
            svat_pkg::CMD_MARK:
            begin
                exec_entry.analyzed = 1'b1;
            end
            default:
            begin
                exec_entry = rd_entry;
            end
        endcase
    end

    // Decide whether the command writes back
    always_comb
    begin
        exec_wr = 1'b0;
        case (req_reg.command) inside
            svat_pkg::CMD_ASSIGN, svat_pkg::CMD_UNASSIGN, svat_pkg::CMD_MARK:
                exec_wr = ctl.exec && in_range;
            default:
                exec_wr = 1'b0;
        endcase
    end

    // Merge the write port
    assign wr_en    = s1_valid_reg || exec_wr;
    assign wr_addr  = s1_valid_reg ? s1_addr_reg : var_addr;
    assign wr_entry = s1_valid_reg ? sweep_entry : exec_entry;

    svat_ram #(
        .WIDTH (svat_pkg::ENTRY_BITS),
        .DEPTH (svat_pkg::NUM_VARS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // Format the response from the updated entry
    always_comb
    begin
        exec_rsp = '0;
        if (in_range)
        begin
            if (exec_entry.assigned)
            begin
                exec_rsp.is_assigned    = 1'b1;
                exec_rsp.truth_value    = exec_entry.truth;
                exec_rsp.reason_present = exec_entry.rvalid;
                exec_rsp.reason_ref     = exec_entry.rvalid ?
                    svat_pkg::OFFSET_BITS'(exec_entry.reason) : '0;
                exec_rsp.level_out      = svat_pkg::LVL_IN_BITS'(exec_entry.level);
                exec_rsp.trail_out      = exec_entry.trail;
            end
            exec_rsp.analyzed_out = exec_entry.analyzed;
        end
    end

    // Hold a response while the output is occupied
    always_ff @(posedge clk)
    begin
        if (ctl.cap_pend)
        begin
            pend_reg <= exec_rsp;
        end
        if (ctl.ld_out)
        begin
            rsp_data_reg <= ctl.out_from_pend ? pend_reg : exec_rsp;
        end
    end

    // Output valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.ld_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid         = rsp_valid_reg;
    assign rsp_data          = rsp_data_reg;
    assign status.sweep_last = sweep_last;
    assign status.out_free   = !rsp_valid_reg || !rsp_stall;

    // Sweep writes and command writes never collide
    a_wr_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !exec_wr)
        else $error("sweep and command write in the same cycle");

    // A loaded response is presented on the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ld_out |=> rsp_valid_reg)
        else $error("loaded response not valid");

    // A stalled response holds its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> (rsp_valid_reg && $stable(rsp_data_reg)))
        else $error("stalled response changed");

endmodule
